/* hdl/afu_pkg.sv */
// Shared types, constants and table generator for the activation function unit.
`timescale 1ns / 1ps

package afu_pkg;

	localparam int unsigned SEGMENTS_DEF = 64;   // default piece count of the sigmoid table
	localparam int unsigned XW           = 24;   // Q7.16 data width
	localparam int unsigned QW           = 17;   // unsigned Q16 value in [0, 1.0]
	localparam int unsigned FRACW        = 19;   // lookup fraction bits
	localparam int unsigned NSTG         = 8;    // pipeline depth

	localparam logic [QW-1:0] Q16_ONE  = 17'h10000;
	localparam logic [QW-1:0] Q16_HALF = 17'h08000;

	typedef enum logic [1:0] {
		MODE_LINEAR  = 2'd0,
		MODE_RELU    = 2'd1,
		MODE_SIGMOID = 2'd2,
		MODE_TANH    = 2'd3
	} act_mode_t;

	// per-item control that rides along with the datapath
	typedef struct packed {
		act_mode_t         mode;
		logic              deriv;
		logic              neg;
		logic [XW-1:0]     direct_y;  // finished result for linear and ReLU
	} ctl_t;

	// restoring long division, elaboration-time use only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem    = rem - d;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sigmoid(8k/segs) in Q16; exp(-u) from a 4th-order series at u/256, squared 8 times
	function automatic logic [QW-1:0] sig_entry(input int unsigned k, input int unsigned segs);
		logic [63:0] u;
		logic [63:0] v;
		logic [63:0] v2;
		logic [63:0] v3;
		logic [63:0] v4;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] q;
		u  = udiv64(64'(k) << 33, 64'(segs));
		v  = u >> 8;
		v2 = (v * v) >> 30;
		v3 = (v2 * v) >> 30;
		v4 = (v3 * v) >> 30;
		e  = (64'd1 << 30) - v + v2 / 2 - v3 / 6 + v4 / 24;
		for (int i = 0; i < 8; i++) begin
			e = (e * e) >> 30;
		end
		den = (64'd1 << 30) + e;
		q   = udiv64((64'd1 << 46) + (den >> 1), den);
		return q[QW-1:0];
	endfunction

endpackage

/* hdl/afu_front.sv */
// Input stages: sign/magnitude split, direct results, table address and fraction.
`timescale 1ns / 1ps

module afu_front import afu_pkg::*; #(
	parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          adv_s1,
	input  logic                          adv_s2,
	input  act_mode_t                     mode,
	input  logic                          deriv,
	input  logic [XW-1:0]                 x_in,
	output ctl_t                          ctl_s2,
	output logic [$clog2(SEGMENTS)-1:0]   idx_s2,
	output logic [FRACW-1:0]              frac_s2,
	output logic                          big_s2
);

	localparam int unsigned IW = $clog2(SEGMENTS);
	localparam int unsigned PW = FRACW + IW;

	ctl_t          ctl_in;
	logic [XW-1:0] mag_in;
	logic          pos_in;

	ctl_t          ctl_s1;
	logic [XW-1:0] mag_s1;

	logic [XW:0]   addr_a;
	logic [PW-1:0] prod_p;

	assign pos_in = !x_in[XW-1] && (x_in != '0);
	assign mag_in = x_in[XW-1] ? (~x_in + XW'(1)) : x_in;

	always_comb begin
		ctl_in.mode  = mode;
		ctl_in.deriv = deriv;
		ctl_in.neg   = x_in[XW-1];
		unique case (mode) inside
			MODE_LINEAR:  ctl_in.direct_y = deriv ? XW'(Q16_ONE) : x_in;
			MODE_RELU:    ctl_in.direct_y = !pos_in ? '0 : (deriv ? XW'(Q16_ONE) : x_in);
			MODE_SIGMOID,
			MODE_TANH:    ctl_in.direct_y = '0;
			default:      ctl_in.direct_y = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ctl_s1 <= ctl_in;
			mag_s1 <= mag_in;
		end
	end

	// tanh reads the sigmoid table at twice the magnitude
	assign addr_a = (ctl_s1.mode == MODE_TANH) ? {mag_s1, 1'b0} : {1'b0, mag_s1};
	assign prod_p = {{IW{1'b0}}, addr_a[FRACW-1:0]} * PW'(SEGMENTS);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ctl_s2  <= ctl_s1;
			big_s2  <= |addr_a[XW:FRACW];
			idx_s2  <= prod_p[PW-1:FRACW];
			frac_s2 <= prod_p[FRACW-1:0];
		end
	end

endmodule

/* hdl/afu_sig_rom.sv */
// Sigmoid table ROM with two registered read ports (segment start and end).
`timescale 1ns / 1ps

module afu_sig_rom import afu_pkg::*; #(
	parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          adv_s3,
	input  ctl_t                          ctl_s2,
	input  logic [$clog2(SEGMENTS)-1:0]   idx_s2,
	input  logic [FRACW-1:0]              frac_s2,
	input  logic                          big_s2,
	output ctl_t                          ctl_s3,
	output logic [QW-1:0]                 t0_s3,
	output logic [QW-1:0]                 t1_s3,
	output logic [FRACW-1:0]              frac_s3,
	output logic                          big_s3
);

	localparam int unsigned AW = $clog2(SEGMENTS + 1);

	logic [QW-1:0] tab [SEGMENTS+1];
	logic [AW-1:0] addr0;
	logic [AW-1:0] addr1;

	for (genvar k = 0; k <= SEGMENTS; k++) begin : g_tab
		assign tab[k] = sig_entry(k, SEGMENTS);
	end

	assign addr0 = AW'(idx_s2);
	assign addr1 = addr0 + AW'(1);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			t0_s3   <= tab[addr0];
			t1_s3   <= tab[addr1];
			ctl_s3  <= ctl_s2;
			frac_s3 <= frac_s2;
			big_s3  <= big_s2;
		end
	end

endmodule

/* hdl/afu_interp.sv */
// Linear interpolation between table entries: slope product, then rounded add.
`timescale 1ns / 1ps

module afu_interp import afu_pkg::*; (
	input  logic             clk,
	input  logic             adv_s4,
	input  logic             adv_s5,
	input  ctl_t             ctl_s3,
	input  logic [QW-1:0]    t0_s3,
	input  logic [QW-1:0]    t1_s3,
	input  logic [FRACW-1:0] frac_s3,
	input  logic             big_s3,
	output ctl_t             ctl_s5,
	output logic [QW-1:0]    smag_s5
);

	localparam int unsigned MW = QW + FRACW;

	logic [QW-1:0] diff;
	logic [MW:0]   rnd_sum;

	ctl_t          ctl_s4;
	logic [MW-1:0] prod_s4;
	logic [QW-1:0] t0_s4;
	logic          big_s4;

	// falling step would clamp to zero slope
	assign diff = (t1_s3 > t0_s3) ? (t1_s3 - t0_s3) : '0;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			prod_s4 <= MW'(diff) * MW'(frac_s3);
			t0_s4   <= t0_s3;
			big_s4  <= big_s3;
			ctl_s4  <= ctl_s3;
		end
	end

	assign rnd_sum = {1'b0, prod_s4} + (MW+1)'(1 << (FRACW - 1));

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			smag_s5 <= big_s4 ? Q16_ONE : (t0_s4 + rnd_sum[FRACW+QW-1:FRACW]);
			ctl_s5  <= ctl_s4;
		end
	end

endmodule

/* hdl/afu_post.sv */
// Output stages: sign fold, derivative product and final result select.
`timescale 1ns / 1ps

module afu_post import afu_pkg::*; (
	input  logic          clk,
	input  logic          adv_s6,
	input  logic          adv_s7,
	input  logic          adv_s8,
	input  ctl_t          ctl_s5,
	input  logic [QW-1:0] smag_s5,
	output logic [XW-1:0] y_s8
);

	localparam int unsigned PW = 2 * QW;

	logic [QW-1:0] sig_v;
	logic [QW:0]   tanh_w;
	logic [PW-1:0] rnd_sum;
	logic [QW-1:0] rnd;
	logic [XW-1:0] fwd_nxt;
	logic [XW-1:0] y_nxt;

	ctl_t          ctl_s6;
	logic [QW-1:0] op_a_s6;
	logic [QW-1:0] op_b_s6;

	ctl_t          ctl_s7;
	logic [PW-1:0] prod_s7;
	logic [XW-1:0] fwd_s7;

	assign sig_v  = ctl_s5.neg ? (Q16_ONE - smag_s5) : smag_s5;
	// tanh = 2*sigmoid(2|x|) - 1, never negative here
	assign tanh_w = {smag_s5, 1'b0} - {1'b0, Q16_ONE};

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			ctl_s6 <= ctl_s5;
			if (ctl_s5.mode == MODE_SIGMOID) begin
				op_a_s6 <= sig_v;
				op_b_s6 <= Q16_ONE - sig_v;
			end else begin
				op_a_s6 <= tanh_w[QW-1:0];
				op_b_s6 <= tanh_w[QW-1:0];
			end
		end
	end

	always_comb begin
		case (ctl_s6.mode) inside
			MODE_LINEAR, MODE_RELU: fwd_nxt = ctl_s6.direct_y;
			MODE_SIGMOID:           fwd_nxt = XW'(op_a_s6);
			default:                fwd_nxt = ctl_s6.neg ? (~XW'(op_a_s6) + XW'(1)) : XW'(op_a_s6);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			ctl_s7  <= ctl_s6;
			prod_s7 <= PW'(op_a_s6) * PW'(op_b_s6);
			fwd_s7  <= fwd_nxt;
		end
	end

	assign rnd_sum = prod_s7 + PW'(1 << 15);
	assign rnd     = rnd_sum[QW+15:16];

	always_comb begin
		case (ctl_s7.mode)
			MODE_SIGMOID: y_nxt = ctl_s7.deriv ? XW'(rnd) : fwd_s7;
			MODE_TANH:    y_nxt = ctl_s7.deriv ? XW'(Q16_ONE - rnd) : fwd_s7;
			default:      y_nxt = fwd_s7;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			y_s8 <= y_nxt;
		end
	end

endmodule

/* hdl/activation_function_unit_core.sv */
// Activation function unit top level: config register, stage valids and flow control.
`timescale 1ns / 1ps
//
// Channel   Dir  Signals                          Payload
// s_*       in   s_tvalid s_tready s_tdata s_tuser  x_value Q7.16 / req_type
// m_*       out  m_tvalid m_tready m_tdata          y_value Q7.16
// cfg_*     in   cfg_valid cfg_ready cfg_data       activation_mode
//
// Eight register stages: sign split, address, table read, slope product, interpolation,
// sign fold, derivative product, output. A result is registered through each stage in
// this order before it is offered; throughput is one transfer per cycle while the output is not stalled.
// Each stage holds a valid bit; a stage loads when it is empty or its successor
// moves, so bubbles close up and an output stall holds items in place.
// Reset clears the valid bits and sets the mode to linear; cfg_ready is always high.

module activation_function_unit_core import afu_pkg::*; #(
	parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [23:0]   s_tdata,   // [23:0] x_value (signed Q7.16)
	input  logic [0:0]    s_tuser,   // [0] req_type (0 value, 1 derivative)
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [23:0]   m_tdata,   // [23:0] y_value (signed Q7.16)
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_data   // [1:0] activation_mode
);

	localparam int unsigned IW = $clog2(SEGMENTS);

	act_mode_t         mode_q;
	logic [NSTG-1:0]   vld_q;
	logic [NSTG:0]     adv;

	ctl_t              ctl_s2;
	logic [IW-1:0]     idx_s2;
	logic [FRACW-1:0]  frac_s2;
	logic              big_s2;

	ctl_t              ctl_s3;
	logic [QW-1:0]     t0_s3;
	logic [QW-1:0]     t1_s3;
	logic [FRACW-1:0]  frac_s3;
	logic              big_s3;

	ctl_t              ctl_s5;
	logic [QW-1:0]     smag_s5;
	logic [XW-1:0]     y_s8;

	// mode register; the user must write it only while the pipe is idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= act_mode_t'(cfg_data);
		end
	end

	// stage k may load when it is empty or stage k+1 loads
	always_comb begin
		adv[NSTG] = m_tready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = vld_q[NSTG-1];
	assign m_tdata  = y_s8;

	afu_front #(.SEGMENTS(SEGMENTS)) u_front (
		.clk     (clk),
		.adv_s1  (adv[0]),
		.adv_s2  (adv[1]),
		.mode    (mode_q),
		.deriv   (s_tuser[0]),
		.x_in    (s_tdata),
		.ctl_s2  (ctl_s2),
		.idx_s2  (idx_s2),
		.frac_s2 (frac_s2),
		.big_s2  (big_s2)
	);

	afu_sig_rom #(.SEGMENTS(SEGMENTS)) u_rom (
		.clk     (clk),
		.adv_s3  (adv[2]),
		.ctl_s2  (ctl_s2),
		.idx_s2  (idx_s2),
		.frac_s2 (frac_s2),
		.big_s2  (big_s2),
		.ctl_s3  (ctl_s3),
		.t0_s3   (t0_s3),
		.t1_s3   (t1_s3),
		.frac_s3 (frac_s3),
		.big_s3  (big_s3)
	);

	afu_interp u_interp (
		.clk     (clk),
		.adv_s4  (adv[3]),
		.adv_s5  (adv[4]),
		.ctl_s3  (ctl_s3),
		.t0_s3   (t0_s3),
		.t1_s3   (t1_s3),
		.frac_s3 (frac_s3),
		.big_s3  (big_s3),
		.ctl_s5  (ctl_s5),
		.smag_s5 (smag_s5)
	);

	afu_post u_post (
		.clk     (clk),
		.adv_s6  (adv[5]),
		.adv_s7  (adv[6]),
		.adv_s8  (adv[7]),
		.ctl_s5  (ctl_s5),
		.smag_s5 (smag_s5),
		.y_s8    (y_s8)
	);

	// an empty output stage means every stage can move, so input is open
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// interpolated sigmoid of a magnitude stays within [0.5, 1.0]
	a_smag_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] |-> (smag_s5 >= Q16_HALF) && (smag_s5 <= Q16_ONE))
		else $error("sigmoid magnitude out of range");

	// a full output stage that is not taken keeps its item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && (m_tdata == $past(m_tdata)))
		else $error("stalled result lost");

endmodule
